/* rtl/core/hlxfp_pkg.sv */
// Shared types and constants for the header/length/XOR frame parser.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package hlxfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int MAX_FRAME_DEF   = 37;

  localparam logic [7:0]  MARKER      = 8'hAA;
  localparam logic [15:0] TIMEOUT_RST = 16'd20;

  // byte positions inside a frame: marker is 0
  localparam int POS_SRC  = 1;
  localparam int POS_DST  = 2;
  localparam int POS_LEN  = 3;
  localparam int POS_DATA = 4;
  localparam int OVERHEAD = 5;

  localparam int LEN_W  = 6;
  localparam int DIDX_W = 5;

  // command queue, power-of-two depth so pointers wrap on their own
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_XOR     = 3'd2,
    ST_FMT     = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  // one queued command: a single status result, or a frame to replay
  typedef struct packed {
    status_t           status;
    logic [7:0]        src;
    logic [7:0]        dst;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hlxfp_front.sv */
// Front end: timeout check, frame parsing, payload writes, command push.
// Depends on hlxfp_pkg.
`default_nettype none

module hlxfp_front #(
  parameter int MAX_PAYLOAD = hlxfp_pkg::MAX_PAYLOAD_DEF,
  parameter int MAX_FRAME   = hlxfp_pkg::MAX_FRAME_DEF
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          cfg_valid,
  output logic                                         cfg_ready,
  input  wire  [15:0]                                  cfg_gap_timeout_ms,
  input  wire                                          in_valid,
  output logic                                         in_ready,
  input  wire                                          in_op,
  input  wire  [7:0]                                   in_rx_byte,
  input  wire  [31:0]                                  in_now_ms,
  input  wire                                          q_full,
  output logic                                         push,
  output hlxfp_pkg::cmd_t                              push_cmd,
  input  wire                                          frame_done,
  output logic                                         mem_we,
  output logic [hlxfp_pkg::addr_w(MAX_PAYLOAD)-1:0]    mem_addr,
  output logic [7:0]                                   mem_data
);

  localparam int AW   = hlxfp_pkg::addr_w(MAX_PAYLOAD);
  localparam int TOPF = (MAX_FRAME > MAX_PAYLOAD + hlxfp_pkg::OVERHEAD) ?
                        MAX_FRAME : MAX_PAYLOAD + hlxfp_pkg::OVERHEAD;
  localparam int CW   = $clog2(TOPF + 1);

  logic [15:0]                  timeout_r, timeout_nxt;
  logic [7:0]                   src_r, src_nxt;
  logic [7:0]                   dst_r, dst_nxt;
  logic [hlxfp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                tot_r, tot_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [31:0]                  last_t_r, last_t_nxt;
  logic                         in_frame_r, in_frame_nxt;
  logic                         busy_r, busy_nxt;

  logic                         accept;
  logic [31:0]                  elapsed;
  logic                         timed;
  logic                         is_marker;
  logic [CW-1:0]                off;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !busy_r;
  assign accept    = in_valid && in_ready;
  assign elapsed   = in_now_ms - last_t_r;
  assign timed     = in_frame_r && (elapsed >= {16'd0, timeout_r});
  assign is_marker = (in_rx_byte == hlxfp_pkg::MARKER);
  assign off       = pos_r - CW'(hlxfp_pkg::POS_DATA);

  always_comb begin
    logic          do_drop;
    logic          do_open;
    logic          live;
    logic          bad_len;
    logic [CW-1:0] tot;

    do_drop      = 1'b0;
    do_open      = 1'b0;
    live         = in_frame_r && !timed;
    bad_len      = 1'b0;
    tot          = tot_r;

    timeout_nxt  = cfg_valid ? cfg_gap_timeout_ms : timeout_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    tot_nxt      = tot_r;
    xor_nxt      = xor_r;
    last_t_nxt   = last_t_r;
    in_frame_nxt = in_frame_r;
    busy_nxt     = frame_done ? 1'b0 : busy_r;

    push         = accept;
    push_cmd     = '{status: hlxfp_pkg::ST_NONE, src: 8'd0, dst: 8'd0,
                     len: '0};
    mem_we       = 1'b0;
    mem_addr     = AW'(off);
    mem_data     = in_rx_byte;

    if (accept) begin
      if (in_op) begin
        if (timed) begin
          do_drop         = 1'b1;
          push_cmd.status = hlxfp_pkg::ST_TIMEOUT;
        end
      end else begin
        if (timed) do_drop = 1'b1;
        if (!live) begin
          do_open = is_marker;
        end else if (pos_r >= CW'(MAX_FRAME)) begin
          do_drop         = 1'b1;
          do_open         = is_marker;
          push_cmd.status = hlxfp_pkg::ST_FMT;
        end else begin
          if (pos_r == CW'(hlxfp_pkg::POS_SRC)) src_nxt = in_rx_byte;
          if (pos_r == CW'(hlxfp_pkg::POS_DST)) dst_nxt = in_rx_byte;
          if (pos_r >= CW'(hlxfp_pkg::POS_DATA) && off < CW'(MAX_PAYLOAD)) mem_we = 1'b1;
          last_t_nxt = in_now_ms;
          if (pos_r == CW'(hlxfp_pkg::POS_LEN)) begin
            if (in_rx_byte > 8'(MAX_PAYLOAD)) begin
              bad_len         = 1'b1;
              do_drop         = 1'b1;
              do_open         = is_marker;
              push_cmd.status = hlxfp_pkg::ST_FMT;
            end else begin
              len_nxt = hlxfp_pkg::LEN_W'(in_rx_byte);
              tot     = CW'(hlxfp_pkg::OVERHEAD) + CW'(in_rx_byte);
            end
          end
          if (!bad_len) begin
            if (tot != '0 && pos_r == tot - CW'(1)) begin
              do_drop = 1'b1;
              if (in_rx_byte != xor_r) begin
                do_open         = is_marker;
                push_cmd.status = hlxfp_pkg::ST_XOR;
              end else begin
                push_cmd = '{status: hlxfp_pkg::ST_DONE, src: src_r, dst: dst_r,
                             len: len_r};
                busy_nxt = 1'b1;
              end
            end else begin
              xor_nxt = xor_r ^ in_rx_byte;
              pos_nxt = pos_r + CW'(1);
              tot_nxt = tot;
            end
          end
        end
      end
    end

    if (do_drop) begin
      pos_nxt      = '0;
      tot_nxt      = '0;
      xor_nxt      = 8'd0;
      last_t_nxt   = 32'd0;
      in_frame_nxt = 1'b0;
    end
    if (do_open) begin
      pos_nxt      = CW'(1);
      tot_nxt      = '0;
      xor_nxt      = hlxfp_pkg::MARKER;
      last_t_nxt   = in_now_ms;
      in_frame_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    if (!rst_n) begin
      timeout_r  <= hlxfp_pkg::TIMEOUT_RST;
      len_r      <= '0;
      pos_r      <= '0;
      tot_r      <= '0;
      xor_r      <= 8'd0;
      last_t_r   <= 32'd0;
      in_frame_r <= 1'b0;
      busy_r     <= 1'b0;
    end else begin
      timeout_r  <= timeout_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      tot_r      <= tot_nxt;
      xor_r      <= xor_nxt;
      last_t_r   <= last_t_nxt;
      in_frame_r <= in_frame_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // position never runs past the overflow point
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CW'(MAX_FRAME))
    else $error("byte position beyond frame limit");

  // idle parser keeps a cleared position and accumulator
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (pos_r == '0 && xor_r == 8'd0 && tot_r == '0))
    else $error("idle parser holds stale frame state");

  // a good frame locks the front until the back end has replayed it
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_cmd.status == hlxfp_pkg::ST_DONE) |=> busy_r)
    else $error("frame pushed without locking the payload store");

endmodule

`default_nettype wire

/* rtl/core/hlxfp_cmd_fifo.sv */
// Two-entry command queue between parser front end and result back end.
// Depends on hlxfp_pkg.
`default_nettype none

module hlxfp_cmd_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  hlxfp_pkg::cmd_t         push_cmd,
  output logic                    full,
  input  wire                     pop,
  output hlxfp_pkg::cmd_t         pop_cmd,
  output logic                    empty
);

  localparam int CNT_W = $clog2(hlxfp_pkg::Q_DEPTH + 1);

  hlxfp_pkg::cmd_t                 q_r [hlxfp_pkg::Q_DEPTH];
  logic [hlxfp_pkg::QP_W-1:0]      wp_r, wp_nxt;
  logic [hlxfp_pkg::QP_W-1:0]      rp_r, rp_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(hlxfp_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full command queue");

  assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty command queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[hlxfp_pkg::QP_W-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* rtl/core/hlxfp_back.sv */
// Back end: pops commands, holds the payload store, drives the result channel.
// Depends on hlxfp_pkg.
`default_nettype none

module hlxfp_back #(
  parameter int MAX_PAYLOAD = hlxfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          q_empty,
  output logic                                         pop,
  input  hlxfp_pkg::cmd_t                              pop_cmd,
  input  wire                                          mem_we,
  input  wire  [hlxfp_pkg::addr_w(MAX_PAYLOAD)-1:0]    mem_addr,
  input  wire  [7:0]                                   mem_data,
  output logic                                         frame_done,
  output logic                                         out_valid,
  input  wire                                          out_ready,
  output logic [2:0]                                   out_status,
  output logic [7:0]                                   out_source,
  output logic [7:0]                                   out_destination,
  output logic [5:0]                                   out_length,
  output logic [7:0]                                   out_data_byte,
  output logic [4:0]                                   out_data_index,
  output logic                                         out_last
);

  localparam int AW  = hlxfp_pkg::addr_w(MAX_PAYLOAD);
  localparam int IXW = hlxfp_pkg::LEN_W + 1;
  localparam int EW  = (AW > hlxfp_pkg::DIDX_W) ? AW : hlxfp_pkg::DIDX_W;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SHOW} state_t;

  state_t            state_r;
  hlxfp_pkg::cmd_t   cur_r;
  logic [AW-1:0]     idx_r;
  logic              done_r;

  logic [7:0]        mem [MAX_PAYLOAD];
  logic [7:0]        rd_data_r;

  logic              is_frame;
  logic              has_data;
  logic [IXW-1:0]    idx_next;
  logic              last_c;
  logic [EW-1:0]     idx_wide;

  assign is_frame = (cur_r.status == hlxfp_pkg::ST_DONE);
  assign has_data = is_frame && (cur_r.len != '0);
  assign idx_next = IXW'(idx_r) + IXW'(1);
  assign last_c   = !has_data || (idx_next == {1'b0, cur_r.len});
  assign idx_wide = EW'(idx_r);
  assign pop      = (state_r == S_IDLE) && !q_empty;

  assign frame_done      = done_r;
  assign out_valid       = (state_r == S_SHOW);
  assign out_status      = cur_r.status;
  assign out_source      = cur_r.src;
  assign out_destination = cur_r.dst;
  assign out_length      = cur_r.len;
  assign out_data_byte   = has_data ? rd_data_r : 8'd0;
  assign out_data_index  = idx_wide[hlxfp_pkg::DIDX_W-1:0];
  assign out_last        = last_c;

  // payload store: written by the front end, read at the replay index
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_data;
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r <= pop_cmd;
            idx_r <= '0;
            if (pop_cmd.status == hlxfp_pkg::ST_DONE && pop_cmd.len != '0) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_SHOW;
            end
          end
        end
        S_READ: begin
          state_r <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) begin
            if (!last_c) begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_READ;
            end else begin
              state_r <= S_IDLE;
              done_r  <= is_frame;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // replay index stays inside the frame's payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && has_data) |-> (IXW'(idx_r) < {1'b0, cur_r.len}))
    else $error("replay index past frame length");

  // store must not change under a frame being replayed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && has_data) |-> !mem_we)
    else $error("payload write during frame replay");

  // completion pulse only follows the taken final result of a frame
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(out_valid && out_ready && out_last && is_frame))
    else $error("frame completion without final result");

endmodule

`default_nettype wire

/* rtl/core/header_length_xor_frame_parser_core.sv */
// Top level of the header/length/XOR frame parser core.
// Depends on hlxfp_pkg, hlxfp_front, hlxfp_cmd_fifo, hlxfp_back.
`default_nettype none

// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  ----------------------------------------
// cfg      in   cfg_valid / cfg_ready  cfg_gap_timeout_ms[15:0]
// in       in   in_valid / in_ready    in_op, in_rx_byte[7:0], in_now_ms[31:0]
// out      out  out_valid / out_ready  status, source, destination, length,
//                                      data_byte, data_index, last
//
// Each input request is parsed combinationally in the cycle it is taken; its
// command lands in a two-entry queue. The back end pops a command in S_IDLE;
// for each payload byte of a good frame it reads the payload store in S_READ,
// then shows the result in S_SHOW until out_ready; other results skip S_READ.
// While a good frame is queued or replaying, in_ready stays low because the
// front end would otherwise overwrite the payload store being read.
// Reset (rst_n low, synchronous) clears control state only; the payload store
// needs no clearing pass. cfg_ready is always high.

module header_length_xor_frame_parser_core #(
  parameter int MAX_PAYLOAD = hlxfp_pkg::MAX_PAYLOAD_DEF,
  parameter int MAX_FRAME   = hlxfp_pkg::MAX_FRAME_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_gap_timeout_ms,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_op,
  input  wire  [7:0]  in_rx_byte,
  input  wire  [31:0] in_now_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_source,
  output logic [7:0]  out_destination,
  output logic [5:0]  out_length,
  output logic [7:0]  out_data_byte,
  output logic [4:0]  out_data_index,
  output logic        out_last
);

  localparam int AW = hlxfp_pkg::addr_w(MAX_PAYLOAD);

  // front -> queue
  logic              push;
  hlxfp_pkg::cmd_t   push_cmd;
  logic              q_full;
  // queue -> back
  logic              pop;
  hlxfp_pkg::cmd_t   pop_cmd;
  logic              q_empty;
  // payload store write port, owned by the front end
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [7:0]        mem_data;
  // back -> front: frame replay finished, store free again
  logic              frame_done;

  hlxfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_FRAME   (MAX_FRAME)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_gap_timeout_ms (cfg_gap_timeout_ms),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_rx_byte         (in_rx_byte),
    .in_now_ms          (in_now_ms),
    .q_full             (q_full),
    .push               (push),
    .push_cmd           (push_cmd),
    .frame_done         (frame_done),
    .mem_we             (mem_we),
    .mem_addr           (mem_addr),
    .mem_data           (mem_data)
  );

  hlxfp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  hlxfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .pop             (pop),
    .pop_cmd         (pop_cmd),
    .mem_we          (mem_we),
    .mem_addr        (mem_addr),
    .mem_data        (mem_data),
    .frame_done      (frame_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_length      (out_length),
    .out_data_byte   (out_data_byte),
    .out_data_index  (out_data_index),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
